// ===== hw/rtl/bgd_pkg.sv =====
// Shared types, codes and sizes for the button gesture detector.
// No dependencies; every other file refers to it by scoped names.
package bgd_pkg;

    localparam int unsigned NUM_W  = 40;   // long dividend width
    localparam int unsigned DEN_W  = 23;   // divisor width (100 * 16 bit)
    localparam int unsigned X_W    = 39;   // 100 * 32-bit time difference

    localparam logic [5:0] DIV_STEPS_LONG  = 6'd40;
    localparam logic [5:0] DIV_STEPS_SHORT = 6'd7;

    // register indexes on the APB port
    localparam logic [2:0] REG_DEBOUNCE     = 3'd0;
    localparam logic [2:0] REG_LONG_PRESS   = 3'd1;
    localparam logic [2:0] REG_DOUBLE_CLICK = 3'd2;
    localparam logic [2:0] REG_CHARGE_FULL  = 3'd3;
    localparam logic [2:0] REG_DECAY        = 3'd4;
    localparam logic [2:0] REG_ACTIVE_LOW   = 3'd5;

    typedef enum logic [2:0] {
        G_NONE   = 3'd0,
        G_DOWN   = 3'd1,
        G_LONG   = 3'd2,
        G_DOUBLE = 3'd3,
        G_CLICK  = 3'd4
    } gesture_t;

    typedef enum logic [1:0] {
        MODE_IDLE     = 2'd0,
        MODE_DEBOUNCE = 2'd1,
        MODE_PRESSED  = 2'd2,
        MODE_WAIT     = 2'd3
    } mode_t;

    typedef enum logic [2:0] {
        ST_IDLE    = 3'd0,
        ST_PREP    = 3'd1,
        ST_DECIDE  = 3'd2,
        ST_LONG    = 3'd3,
        ST_SHORT_C = 3'd4,
        ST_SHORT_D = 3'd5,
        ST_DONE    = 3'd6
    } ctrl_state_t;

    typedef struct packed {
        logic [31:0] now_ms;
        logic        pin_level;
        logic        edge_seen;
        logic        clear_counters;
    } in_t;

    typedef struct packed {
        gesture_t    gesture;
        logic [6:0]  charge_percent;
        logic [15:0] click_total;
        logic [15:0] double_click_total;
        logic [15:0] long_press_total;
    } out_t;

    typedef struct packed {
        logic [15:0] debounce_ms;
        logic [15:0] long_press_ms;
        logic [15:0] double_click_ms;
        logic [15:0] charge_full_ms;
        logic [15:0] decay_ms;
        logic        active_low;
    } cfg_t;

    typedef struct packed {
        logic load;          // accept item, advance gesture machine
        logic prep;          // form 100*dt and level*divisor
        logic start_long;    // (level*d + 100*dt) / (100*d)
        logic start_short_c; // charge remainder / d
        logic start_short_d; // 100*dt / d for decay
        logic take_long;     // add whole hundreds to long-press count
        logic take_short_c;  // new charge level
        logic take_short_d;  // subtract decay step
        logic clear_decay;   // decay drains to zero
        logic out_load;      // write result register
    } cmd_t;

    typedef struct packed {
        logic charging;
        logic decay_ok;
        logic step_ok;
        logic decay_zero;
        logic div_busy;
        logic out_free;
    } status_t;

endpackage

// ===== hw/rtl/bgd_div.sv =====
// Serial restoring divider, one quotient bit per cycle.
// Long mode runs 40 steps; short mode runs 7 (quotient known below 128).
// Depends on bgd_pkg.
module bgd_div (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    input  logic                     short_mode,
    input  logic [bgd_pkg::NUM_W-1:0] dividend,
    input  logic [bgd_pkg::DEN_W-1:0] divisor,
    output logic                     busy,
    output logic [bgd_pkg::NUM_W-1:0] quotient,
    output logic [bgd_pkg::DEN_W-1:0] remainder
);

    logic [bgd_pkg::DEN_W-1:0] rem_reg, rem_next;
    logic [bgd_pkg::NUM_W-1:0] shf_reg, shf_next;
    logic [bgd_pkg::DEN_W-1:0] den_reg, den_next;
    logic [5:0]                cnt_reg, cnt_next;
    logic                      busy_reg, busy_next;
    logic [bgd_pkg::DEN_W:0]   trial;
    logic [bgd_pkg::DEN_W:0]   diff;
    logic                      fits;

    assign trial = {rem_reg, shf_reg[bgd_pkg::NUM_W-1]};
    assign diff  = trial - {1'b0, den_reg};
    assign fits  = (trial >= {1'b0, den_reg});

    always_comb
    begin
        rem_next  = rem_reg;
        shf_next  = shf_reg;
        den_next  = den_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        if (start)
        begin
            den_next  = divisor;
            busy_next = 1'b1;
            if (short_mode)
            begin
                rem_next = {7'd0, dividend[22:7]};
                shf_next = {dividend[6:0], 33'd0};
                cnt_next = bgd_pkg::DIV_STEPS_SHORT;
            end
            else
            begin
                rem_next = '0;
                shf_next = dividend;
                cnt_next = bgd_pkg::DIV_STEPS_LONG;
            end
        end
        else if (busy_reg)
        begin
            if (fits)
                rem_next = diff[bgd_pkg::DEN_W-1:0];
            else
                rem_next = trial[bgd_pkg::DEN_W-1:0];
            shf_next  = {shf_reg[bgd_pkg::NUM_W-2:0], fits};
            cnt_next  = cnt_reg - 6'd1;
            busy_next = (cnt_reg != 6'd1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        shf_reg <= shf_next;
        den_reg <= den_next;
    end

    assign busy      = busy_reg;
    assign quotient  = shf_reg;
    assign remainder = rem_reg;

endmodule

// ===== hw/rtl/bgd_datapath.sv =====
// Gesture state, charge state, counters, operand registers and result register.
// Depends on bgd_pkg and bgd_div.
module bgd_datapath (
    input  logic             clk,
    input  logic             rst_n,
    input  bgd_pkg::cfg_t    cfg,
    input  bgd_pkg::in_t     in_item,
    input  bgd_pkg::cmd_t    cmd,
    output bgd_pkg::status_t stat,
    output logic             out_valid,
    input  logic             out_stall,
    output bgd_pkg::out_t    out_item
);

    // architectural state
    bgd_pkg::mode_t  mode_reg, mode_next;
    logic            pend_reg, pend_next;
    logic [31:0]     win_reg, win_next;
    logic [31:0]     pstart_reg, pstart_next;
    logic            scw_reg, scw_next;
    logic            lfired_reg, lfired_next;
    logic            chg_reg, chg_next;
    logic [6:0]      cl_reg, cl_next;
    logic [31:0]     cstart_reg, cstart_next;
    logic [31:0]     dstart_reg, dstart_next;
    logic [15:0]     clicks_reg, clicks_next;
    logic [15:0]     dclicks_reg, dclicks_next;
    logic [15:0]     lp_reg, lp_next;

    // per-item working registers
    logic [31:0]             now_reg;
    logic                    pressed_reg;
    bgd_pkg::gesture_t       gest_reg, gest_next;
    logic [bgd_pkg::X_W-1:0] x_reg;
    logic [22:0]             prod_reg;
    logic [15:0]             deff_reg;

    logic                    out_valid_reg;
    bgd_pkg::out_t           out_reg;

    logic                      pressed;
    logic [15:0]               charge_eff, decay_eff, deff;
    logic [31:0]               dt;
    logic [bgd_pkg::X_W-1:0]   x_full;
    logic [22:0]               prod_full;
    logic [bgd_pkg::DEN_W-1:0] den_long, div_den;
    logic [bgd_pkg::NUM_W-1:0] num_long, div_num;
    logic                      div_start, div_short, div_busy;
    logic [bgd_pkg::NUM_W-1:0] div_q;
    logic [bgd_pkg::DEN_W-1:0] div_r;

    assign pressed    = cfg.active_low ? !in_item.pin_level : in_item.pin_level;
    assign charge_eff = (cfg.charge_full_ms == 16'd0) ? 16'd1 : cfg.charge_full_ms;
    assign decay_eff  = (cfg.decay_ms == 16'd0) ? 16'd1 : cfg.decay_ms;
    assign deff       = chg_reg ? charge_eff : decay_eff;
    assign dt         = now_reg - (chg_reg ? cstart_reg : dstart_reg);
    assign x_full     = {7'd0, dt} * 39'd100;
    assign prod_full  = {7'd0, deff} * {16'd0, cl_reg};

    assign den_long = {7'd0, deff_reg} * 23'd100;
    assign num_long = {17'd0, prod_reg} + {1'b0, x_reg};

    always_comb
    begin
        div_start = cmd.start_long | cmd.start_short_c | cmd.start_short_d;
        div_short = !cmd.start_long;
        div_den   = {7'd0, deff_reg};
        div_num   = {1'b0, x_reg};
        if (cmd.start_long)
        begin
            div_den = den_long;
            div_num = num_long;
        end
        else if (cmd.start_short_c)
        begin
            div_num = {17'd0, div_r};
        end
    end

    bgd_div u_div (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (div_start),
        .short_mode (div_short),
        .dividend   (div_num),
        .divisor    (div_den),
        .busy       (div_busy),
        .quotient   (div_q),
        .remainder  (div_r)
    );

    always_comb
    begin
        mode_next    = mode_reg;
        pend_next    = pend_reg;
        win_next     = win_reg;
        pstart_next  = pstart_reg;
        scw_next     = scw_reg;
        lfired_next  = lfired_reg;
        chg_next     = chg_reg;
        cl_next      = cl_reg;
        cstart_next  = cstart_reg;
        dstart_next  = dstart_reg;
        clicks_next  = clicks_reg;
        dclicks_next = dclicks_reg;
        lp_next      = lp_reg;
        gest_next    = gest_reg;

        if (cmd.load)
        begin
            if (in_item.clear_counters)
            begin
                clicks_next  = '0;
                dclicks_next = '0;
                lp_next      = '0;
            end
            pend_next = pend_reg | in_item.edge_seen;
            gest_next = bgd_pkg::G_NONE;
            case (mode_reg)
                bgd_pkg::MODE_IDLE:
                begin
                    if (pend_next)
                    begin
                        pend_next = 1'b0;
                        mode_next = bgd_pkg::MODE_DEBOUNCE;
                        win_next  = in_item.now_ms;
                    end
                end
                bgd_pkg::MODE_DEBOUNCE:
                begin
                    if ((in_item.now_ms - win_reg) >= {16'd0, cfg.debounce_ms})
                    begin
                        pend_next = 1'b0;
                        if (pressed)
                        begin
                            mode_next   = bgd_pkg::MODE_PRESSED;
                            pstart_next = in_item.now_ms;
                            lfired_next = 1'b0;
                            chg_next    = 1'b0;
                            gest_next   = bgd_pkg::G_DOWN;
                        end
                        else
                        begin
                            mode_next = bgd_pkg::MODE_IDLE;
                        end
                    end
                end
                bgd_pkg::MODE_PRESSED:
                begin
                    if (!pressed)
                    begin
                        pend_next   = 1'b0;
                        chg_next    = 1'b0;
                        dstart_next = in_item.now_ms;
                        if ((in_item.now_ms - pstart_reg) >= {16'd0, cfg.long_press_ms})
                        begin
                            if (!lfired_reg)
                            begin
                                lfired_next = 1'b1;
                                gest_next   = bgd_pkg::G_LONG;
                            end
                            mode_next = bgd_pkg::MODE_IDLE;
                        end
                        else if (scw_reg)
                        begin
                            scw_next     = 1'b0;
                            dclicks_next = dclicks_next + 16'd1;
                            gest_next    = bgd_pkg::G_DOUBLE;
                            mode_next    = bgd_pkg::MODE_IDLE;
                        end
                        else
                        begin
                            mode_next = bgd_pkg::MODE_WAIT;
                            win_next  = in_item.now_ms;
                        end
                    end
                    else if (((in_item.now_ms - pstart_reg) >= {16'd0, cfg.long_press_ms})
                             && !lfired_reg)
                    begin
                        lfired_next = 1'b1;
                        chg_next    = 1'b1;
                        cstart_next = in_item.now_ms;
                        gest_next   = bgd_pkg::G_LONG;
                    end
                end
                default:
                begin
                    if (pend_next)
                    begin
                        pend_next = 1'b0;
                        scw_next  = 1'b1;
                        mode_next = bgd_pkg::MODE_DEBOUNCE;
                        win_next  = in_item.now_ms;
                    end
                    else if ((in_item.now_ms - win_reg) >= {16'd0, cfg.double_click_ms})
                    begin
                        clicks_next = clicks_next + 16'd1;
                        gest_next   = bgd_pkg::G_CLICK;
                        mode_next   = bgd_pkg::MODE_IDLE;
                    end
                    else if (pressed)
                    begin
                        scw_next  = 1'b1;
                        mode_next = bgd_pkg::MODE_DEBOUNCE;
                        win_next  = in_item.now_ms;
                    end
                end
            endcase
        end

        // charge update steps
        if (cmd.take_long)
            lp_next = lp_reg + div_q[15:0];
        if (cmd.take_short_c)
        begin
            cl_next     = div_q[6:0];
            cstart_next = now_reg;
        end
        if (cmd.take_short_d)
        begin
            cl_next     = cl_reg - div_q[6:0];
            dstart_next = now_reg;
        end
        if (cmd.clear_decay)
        begin
            cl_next     = '0;
            dstart_next = now_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg      <= bgd_pkg::MODE_IDLE;
            pend_reg      <= 1'b0;
            win_reg       <= '0;
            pstart_reg    <= '0;
            scw_reg       <= 1'b0;
            lfired_reg    <= 1'b0;
            chg_reg       <= 1'b0;
            cl_reg        <= '0;
            cstart_reg    <= '0;
            dstart_reg    <= '0;
            clicks_reg    <= '0;
            dclicks_reg   <= '0;
            lp_reg        <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            mode_reg    <= mode_next;
            pend_reg    <= pend_next;
            win_reg     <= win_next;
            pstart_reg  <= pstart_next;
            scw_reg     <= scw_next;
            lfired_reg  <= lfired_next;
            chg_reg     <= chg_next;
            cl_reg      <= cl_next;
            cstart_reg  <= cstart_next;
            dstart_reg  <= dstart_next;
            clicks_reg  <= clicks_next;
            dclicks_reg <= dclicks_next;
            lp_reg      <= lp_next;
            if (cmd.out_load)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        gest_reg <= gest_next;
        if (cmd.load)
        begin
            now_reg     <= in_item.now_ms;
            pressed_reg <= pressed;
        end
        if (cmd.prep)
        begin
            x_reg    <= x_full;
            prod_reg <= prod_full;
            deff_reg <= deff;
        end
        if (cmd.out_load)
        begin
            out_reg.gesture            <= gest_reg;
            out_reg.charge_percent     <= cl_reg;
            out_reg.click_total        <= clicks_reg;
            out_reg.double_click_total <= dclicks_reg;
            out_reg.long_press_total   <= lp_reg;
        end
    end

    assign stat.charging   = chg_reg;
    assign stat.decay_ok   = !pressed_reg && (cl_reg != 7'd0);
    assign stat.step_ok    = (x_reg >= {23'd0, deff_reg});
    assign stat.decay_zero = (x_reg >= {16'd0, prod_reg});
    assign stat.div_busy   = div_busy;
    assign stat.out_free   = !out_valid_reg || !out_stall;

    assign out_valid = out_valid_reg;
    assign out_item  = out_reg;

endmodule

// ===== hw/rtl/bgd_ctrl.sv =====
// Sequencer for one item: gesture step, operand prep, divider runs, result write.
// Depends on bgd_pkg.
module bgd_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_stall,
    input  bgd_pkg::status_t stat,
    output bgd_pkg::cmd_t    cmd
);

    bgd_pkg::ctrl_state_t state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            bgd_pkg::ST_IDLE:
                if (in_valid)
                    state_next = bgd_pkg::ST_PREP;
            bgd_pkg::ST_PREP:
                state_next = bgd_pkg::ST_DECIDE;
            bgd_pkg::ST_DECIDE:
            begin
                if (stat.charging)
                    state_next = stat.step_ok ? bgd_pkg::ST_LONG : bgd_pkg::ST_DONE;
                else if (stat.decay_ok && stat.step_ok && !stat.decay_zero)
                    state_next = bgd_pkg::ST_SHORT_D;
                else
                    state_next = bgd_pkg::ST_DONE;
            end
            bgd_pkg::ST_LONG:
                if (!stat.div_busy)
                    state_next = bgd_pkg::ST_SHORT_C;
            bgd_pkg::ST_SHORT_C,
            bgd_pkg::ST_SHORT_D:
                if (!stat.div_busy)
                    state_next = bgd_pkg::ST_DONE;
            bgd_pkg::ST_DONE:
                if (stat.out_free)
                    state_next = bgd_pkg::ST_IDLE;
            default:
                state_next = bgd_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        in_stall = 1'b1;
        case (state_reg)
            bgd_pkg::ST_IDLE:
            begin
                in_stall = 1'b0;
                cmd.load = in_valid;
            end
            bgd_pkg::ST_PREP:
                cmd.prep = 1'b1;
            bgd_pkg::ST_DECIDE:
            begin
                if (stat.charging)
                    cmd.start_long = stat.step_ok;
                else if (stat.decay_ok && stat.step_ok)
                begin
                    cmd.clear_decay   = stat.decay_zero;
                    cmd.start_short_d = !stat.decay_zero;
                end
            end
            bgd_pkg::ST_LONG:
            begin
                cmd.take_long     = !stat.div_busy;
                cmd.start_short_c = !stat.div_busy;
            end
            bgd_pkg::ST_SHORT_C:
                cmd.take_short_c = !stat.div_busy;
            bgd_pkg::ST_SHORT_D:
                cmd.take_short_d = !stat.div_busy;
            bgd_pkg::ST_DONE:
                cmd.out_load = stat.out_free;
            default:
                cmd = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= bgd_pkg::ST_IDLE;
        else
            state_reg <= state_next;
    end

endmodule

// ===== hw/rtl/button_gesture_detector_unit.sv =====
// Button gesture detector: debounce, click, double click, long press, charge.
// Sequence: item taken, operand prep, decide, then a 40-step and a 7-step serial division
// for a charge step or one 7-step division for a decay step, then the result write.
// Items: the next item is taken only after the last result is written; a stalled result
// waits in the output register and only holds the next item in its final state.
// Reset: async active-low rst_n clears state; config 20/1000/300/2000/3000 ms, active low.
module button_gesture_detector_unit (
    input  logic                clk,
    input  logic                rst_n,
    // poll items in
    input  logic                in_valid,
    output logic                in_stall,
    input  bgd_pkg::in_t        in_item,
    // result items out
    output logic                out_valid,
    input  logic                out_stall,
    output bgd_pkg::out_t       out_item,
    // APB configuration port
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [4:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);

    // configuration registers
    bgd_pkg::cfg_t cfg_reg, cfg_next;
    logic          wr_en;
    logic [2:0]    reg_idx;

    bgd_pkg::cmd_t    cmd;
    bgd_pkg::status_t stat;

    assign pready  = 1'b1;
    assign reg_idx = paddr[4:2];
    assign wr_en   = psel && penable && pwrite;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (reg_idx)
                bgd_pkg::REG_DEBOUNCE:     cfg_next.debounce_ms     = pwdata[15:0];
                bgd_pkg::REG_LONG_PRESS:   cfg_next.long_press_ms   = pwdata[15:0];
                bgd_pkg::REG_DOUBLE_CLICK: cfg_next.double_click_ms = pwdata[15:0];
                bgd_pkg::REG_CHARGE_FULL:  cfg_next.charge_full_ms  = pwdata[15:0];
                bgd_pkg::REG_DECAY:        cfg_next.decay_ms        = pwdata[15:0];
                bgd_pkg::REG_ACTIVE_LOW:   cfg_next.active_low      = pwdata[0];
                default:                   cfg_next = cfg_reg;  // unmapped: ignored
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx)
            bgd_pkg::REG_DEBOUNCE:     prdata = {16'd0, cfg_reg.debounce_ms};
            bgd_pkg::REG_LONG_PRESS:   prdata = {16'd0, cfg_reg.long_press_ms};
            bgd_pkg::REG_DOUBLE_CLICK: prdata = {16'd0, cfg_reg.double_click_ms};
            bgd_pkg::REG_CHARGE_FULL:  prdata = {16'd0, cfg_reg.charge_full_ms};
            bgd_pkg::REG_DECAY:        prdata = {16'd0, cfg_reg.decay_ms};
            bgd_pkg::REG_ACTIVE_LOW:   prdata = {31'd0, cfg_reg.active_low};
            default:                   prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.debounce_ms     <= 16'd20;
            cfg_reg.long_press_ms   <= 16'd1000;
            cfg_reg.double_click_ms <= 16'd300;
            cfg_reg.charge_full_ms  <= 16'd2000;
            cfg_reg.decay_ms        <= 16'd3000;
            cfg_reg.active_low      <= 1'b1;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // sequencer: one item through gesture step, charge arithmetic, result write
    bgd_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .stat     (stat),
        .cmd      (cmd)
    );

    // state, serial divider and the output register
    bgd_datapath u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .in_item   (in_item),
        .cmd       (cmd),
        .stat      (stat),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_item  (out_item)
    );

endmodule

// ===== bench/tb_button_gesture_detector_unit.sv =====
// Self-checking bench for button_gesture_detector_unit: poll items in, gesture results out.
// Needs bgd_pkg and the RTL top only; an internal scoreboard predicts every result.
module tb_button_gesture_detector_unit;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int ITEM_TARGET = 950;
    localparam int DRAIN_WAIT  = 60;     // longest item latency plus margin
    localparam int LONG_HOLD   = 600;    // receiver hold-off, in cycles
    localparam int PHASE_ITEMS = 110;

    // ------------------------------------------------------------------
    // Scoreboard: private copy of the gesture machine, charge and counters.
    // note_poll() runs once per accepted poll item, check_result() once per
    // accepted result item.
    // ------------------------------------------------------------------
    class gesture_scoreboard;
        bgd_pkg::cfg_t  cfg;
        bgd_pkg::mode_t mode;
        bit          press_armed;       // falling edge seen, not yet consumed
        bit          second_wait;       // a second click is being looked for
        bit          long_done;
        bit          filling;           // charge is filling while held
        logic [31:0] window_t0, press_t0, fill_t0, drain_t0;
        logic [6:0]  level;
        logic [15:0] clicks, doubles, longs;
        bgd_pkg::out_t expected_q[$];
        int          errors;

        function new();
            cfg.debounce_ms     = 16'd20;
            cfg.long_press_ms   = 16'd1000;
            cfg.double_click_ms = 16'd300;
            cfg.charge_full_ms  = 16'd2000;
            cfg.decay_ms        = 16'd3000;
            cfg.active_low      = 1'b1;
            mode        = bgd_pkg::MODE_IDLE;
            press_armed = 0;
            second_wait = 0;
            long_done   = 0;
            filling     = 0;
            window_t0   = '0;
            press_t0    = '0;
            fill_t0     = '0;
            drain_t0    = '0;
            level       = '0;
            clicks      = '0;
            doubles     = '0;
            longs       = '0;
            errors      = 0;
        endfunction

        function void set_reg(logic [2:0] idx, logic [15:0] val);
            case (idx)
                bgd_pkg::REG_DEBOUNCE:     cfg.debounce_ms     = val;
                bgd_pkg::REG_LONG_PRESS:   cfg.long_press_ms   = val;
                bgd_pkg::REG_DOUBLE_CLICK: cfg.double_click_ms = val;
                bgd_pkg::REG_CHARGE_FULL:  cfg.charge_full_ms  = val;
                bgd_pkg::REG_DECAY:        cfg.decay_ms        = val;
                bgd_pkg::REG_ACTIVE_LOW:   cfg.active_low      = val[0];
                default: ;
            endcase
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        task report(string what, longint got, longint want);
            errors++;
            $display("[%0t] MISMATCH %s: got %0d, expected %0d", $realtime, what, got, want);
        endtask

        function void note_poll(bgd_pkg::in_t it);
            logic [31:0]       now, dt;
            logic [63:0]       step, total, fdiv, ddiv;
            logic              pressed;
            bgd_pkg::gesture_t g;
            bgd_pkg::out_t     r;
            now     = it.now_ms;
            pressed = cfg.active_low ? !it.pin_level : it.pin_level;
            g       = bgd_pkg::G_NONE;
            fdiv    = (cfg.charge_full_ms == 0) ? 64'd1 : 64'(cfg.charge_full_ms);
            ddiv    = (cfg.decay_ms == 0) ? 64'd1 : 64'(cfg.decay_ms);

            if (it.clear_counters) begin
                clicks  = '0;
                doubles = '0;
                longs   = '0;
            end
            if (it.edge_seen)
                press_armed = 1;

            case (mode)
                bgd_pkg::MODE_IDLE: begin
                    if (press_armed) begin
                        press_armed = 0;
                        mode        = bgd_pkg::MODE_DEBOUNCE;
                        window_t0   = now;
                    end
                end
                bgd_pkg::MODE_DEBOUNCE: begin
                    dt = now - window_t0;
                    if (dt >= 32'(cfg.debounce_ms)) begin
                        press_armed = 0;
                        if (pressed) begin
                            mode      = bgd_pkg::MODE_PRESSED;
                            press_t0  = now;
                            long_done = 0;
                            filling   = 0;
                            g         = bgd_pkg::G_DOWN;
                        end else begin
                            mode = bgd_pkg::MODE_IDLE;
                        end
                    end
                end
                bgd_pkg::MODE_PRESSED: begin
                    dt = now - press_t0;
                    if (!pressed) begin
                        press_armed = 0;
                        filling     = 0;
                        drain_t0    = now;
                        if (dt >= 32'(cfg.long_press_ms)) begin
                            // released past the threshold: long press, but no charging
                            if (!long_done) begin
                                long_done = 1;
                                g         = bgd_pkg::G_LONG;
                            end
                            mode = bgd_pkg::MODE_IDLE;
                        end else if (second_wait) begin
                            second_wait = 0;
                            doubles     = doubles + 16'd1;
                            g           = bgd_pkg::G_DOUBLE;
                            mode        = bgd_pkg::MODE_IDLE;
                        end else begin
                            mode      = bgd_pkg::MODE_WAIT;
                            window_t0 = now;
                        end
                    end else if (dt >= 32'(cfg.long_press_ms) && !long_done) begin
                        long_done = 1;
                        filling   = 1;
                        fill_t0   = now;
                        g         = bgd_pkg::G_LONG;
                    end
                end
                default: begin
                    dt = now - window_t0;
                    if (press_armed) begin
                        press_armed = 0;
                        second_wait = 1;
                        mode        = bgd_pkg::MODE_DEBOUNCE;
                        window_t0   = now;
                    end else if (dt >= 32'(cfg.double_click_ms)) begin
                        clicks = clicks + 16'd1;
                        g      = bgd_pkg::G_CLICK;
                        mode   = bgd_pkg::MODE_IDLE;
                    end else if (pressed) begin
                        second_wait = 1;
                        mode        = bgd_pkg::MODE_DEBOUNCE;
                        window_t0   = now;
                    end
                end
            endcase

            // charge fills while held past the threshold, drains after release
            if (filling) begin
                dt   = now - fill_t0;
                step = (64'(dt) * 64'd100) / fdiv;
                if (step >= 1) begin
                    total   = 64'(level) + step;
                    fill_t0 = now;
                    longs   = longs + 16'(total / 64'd100);
                    level   = 7'(total % 64'd100);
                end
            end else if (!pressed && level > 0) begin
                dt   = now - drain_t0;
                step = (64'(dt) * 64'd100) / ddiv;
                if (step >= 1) begin
                    drain_t0 = now;
                    if (step >= 64'(level))
                        level = '0;
                    else
                        level = level - 7'(step);
                end
            end

            r.gesture            = g;
            r.charge_percent     = level;
            r.click_total        = clicks;
            r.double_click_total = doubles;
            r.long_press_total   = longs;
            expected_q.push_back(r);
        endfunction

        task check_result(bgd_pkg::out_t got);
            bgd_pkg::out_t want;
            if (expected_q.size() == 0) begin
                report("result with nothing expected, gesture", got.gesture, 0);
                return;
            end
            want = expected_q.pop_front();
            if (got.gesture !== want.gesture)
                report("gesture", got.gesture, want.gesture);
            if (got.charge_percent !== want.charge_percent)
                report("charge_percent", got.charge_percent, want.charge_percent);
            if (got.click_total !== want.click_total)
                report("click_total", got.click_total, want.click_total);
            if (got.double_click_total !== want.double_click_total)
                report("double_click_total", got.double_click_total, want.double_click_total);
            if (got.long_press_total !== want.long_press_total)
                report("long_press_total", got.long_press_total, want.long_press_total);
        endtask
    endclass

    // ------------------------------------------------------------------
    // DUT and bench signals
    // ------------------------------------------------------------------
    logic          clk = 1'b0;
    logic          rst_n;
    logic          in_valid;
    logic          in_stall;
    bgd_pkg::in_t  in_item;
    logic          out_valid;
    logic          out_stall = 1'b0;
    bgd_pkg::out_t out_item;
    logic          psel;
    logic          penable;
    logic          pwrite;
    logic [4:0]    paddr;
    logic [31:0]   pwdata;
    logic [31:0]   prdata;
    logic          pready;

    gesture_scoreboard sb = new();

    logic [31:0] now_t;             // poll time stamp the sender walks forward
    int          items_sent = 0;
    bit          tx_burst = 0;      // sender runs back to back while set
    bit          rx_burst = 0;      // receiver draws no random stall while set
    int          rx_wait = 0;
    int          results_seen = 0;
    logic        rx_hold = 1'b0;    // long receiver hold-off in progress
    bit          hold_req = 0;
    int          cycle_count = 0;

    button_gesture_detector_unit u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .in_item  (in_item),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .out_item (out_item),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always #4 clk = ~clk;

    // Watchdog: a hang anywhere ends the run as a failure.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Result side: check every accepted result, then draw the stall that
    // precedes the next one. Bursts of zero stall alternate with random
    // stalls; rx_hold overrides everything.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall) begin
            sb.check_result(out_item);
            results_seen++;
            if (results_seen % 45 == 0)
                rx_burst = ($urandom_range(0, 2) == 0);
            rx_wait = rx_burst ? 0 : int'($urandom_range(0, 14));
        end
        if (rx_hold || rx_wait > 0)
            out_stall <= 1'b1;
        else
            out_stall <= 1'b0;
        if (!rx_hold && rx_wait > 0)
            rx_wait--;
    end

    // Long hold-off: once requested, the receiver stalls while the sender keeps offering
    // polls, so the block backs up into in_stall.
    initial
    begin
        wait (hold_req);
        @(posedge clk);
        rx_hold <= 1'b1;
        repeat (LONG_HOLD) @(posedge clk);
        rx_hold <= 1'b0;
    end

    // ------------------------------------------------------------------
    // Sender tasks. All of them start and end aligned to a rising edge.
    // ------------------------------------------------------------------
    task automatic send_poll(logic [31:0] t, logic pin, logic fell, logic clr);
        int gap;
        bgd_pkg::in_t it;
        if (items_sent % 40 == 0)
            tx_burst = ($urandom_range(0, 2) == 0);
        gap = tx_burst ? 0 : int'($urandom_range(0, 14));
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        it.now_ms         = t;
        it.pin_level      = pin;
        it.edge_seen      = fell;
        it.clear_counters = clr;
        in_item  <= it;
        in_valid <= 1'b1;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        sb.note_poll(it);
        items_sent++;
    endtask

    // One poll at now_t; 'down' is the logical button state, mapped to a pin
    // level through the current polarity. Counter clears are sprinkled in.
    task automatic poll(bit down, bit fell);
        logic pin;
        pin = sb.cfg.active_low ? !down : down;
        send_poll(now_t, pin, fell, $urandom_range(0, 19) == 0);
    endtask

    // Block goes idle: every result in, then the worst-case latency again.
    task automatic drain();
        in_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
    endtask

    task automatic cfg_write(logic [2:0] idx, logic [15:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= 32'(val);
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        sb.set_reg(idx, val);
        @(posedge clk);
    endtask

    task automatic cfg_all(logic [15:0] db, logic [15:0] lp, logic [15:0] dc,
                           logic [15:0] cf, logic [15:0] dk, logic al);
        cfg_write(bgd_pkg::REG_DEBOUNCE, db);
        cfg_write(bgd_pkg::REG_LONG_PRESS, lp);
        cfg_write(bgd_pkg::REG_DOUBLE_CLICK, dc);
        cfg_write(bgd_pkg::REG_CHARGE_FULL, cf);
        cfg_write(bgd_pkg::REG_DECAY, dk);
        cfg_write(bgd_pkg::REG_ACTIVE_LOW, {15'd0, al});
    endtask

    // Edge, press-down after debounce, 'polls' polls while held, then release.
    // The release comes roughly 'hold' ms after the press-down poll.
    task automatic press(int unsigned hold, int polls);
        int unsigned step;
        step = hold / (polls + 1);
        poll(1, 1);
        now_t += sb.cfg.debounce_ms + $urandom_range(0, 3);
        poll(1, 0);
        for (int i = 0; i < polls; i++) begin
            now_t += step;
            poll(1, 0);
        end
        now_t += step + 1;
        poll(0, 0);
    endtask

    // Released polls spread over roughly 'span' ms.
    task automatic released(int unsigned span, int polls);
        for (int i = 0; i < polls; i++) begin
            now_t += span / polls + $urandom_range(0, 2);
            poll(0, 0);
        end
    endtask

    // One random gesture: mostly well-formed clicks, double clicks and long
    // holds with random timing, plus bounces and raw noise.
    task automatic episode();
        int unsigned lp, dc, cf, dk, db;
        int kind;
        lp   = sb.cfg.long_press_ms;
        dc   = sb.cfg.double_click_ms;
        cf   = sb.cfg.charge_full_ms;
        dk   = sb.cfg.decay_ms;
        db   = sb.cfg.debounce_ms;
        kind = int'($urandom_range(0, 9));
        case (kind)
            0, 1, 2: begin  // single click
                press($urandom_range(0, lp / 2), int'($urandom_range(0, 2)));
                released(dc + 5, int'($urandom_range(1, 3)));
            end
            3, 4: begin     // double click
                press($urandom_range(0, lp / 2), int'($urandom_range(0, 1)));
                released(dc / 2, 1);
                press($urandom_range(0, lp / 2), int'($urandom_range(0, 1)));
                released(dc + 5, int'($urandom_range(1, 2)));
            end
            5, 6: begin     // long hold with charging, then drain
                press(lp + $urandom_range(0, 3 * cf), int'($urandom_range(2, 8)));
                released(2 * dk, int'($urandom_range(1, 5)));
            end
            7: begin        // bounce on the second click leaves the flag armed
                press($urandom_range(0, lp / 2), 0);
                released(dc / 4, 1);
                poll(1, 1);
                now_t += db;
                poll(0, 0);
                press($urandom_range(0, lp / 2), int'($urandom_range(0, 1)));
                released(dc + 5, 1);
            end
            8: begin        // plain bounce from idle
                poll(1, 1);
                now_t += db + $urandom_range(0, 2);
                poll(0, 0);
            end
            default: begin  // noise, occasionally with huge time jumps
                repeat ($urandom_range(1, 5)) begin
                    now_t += ($urandom_range(0, 7) == 0) ? $urandom : $urandom_range(0, 300);
                    send_poll(now_t, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                              $urandom_range(0, 7) == 0);
                end
            end
        endcase
    endtask

    // ------------------------------------------------------------------
    // Directed polls under the reset configuration (pressed = pin low).
    // Fields per entry: {pin_level, edge_seen, clear_counters}.
    // ------------------------------------------------------------------
    logic [31:0] dir_time[29] = '{
        32'd0, 32'd5, 32'd25, 32'd100, 32'd450,                 // click
        32'd500, 32'd520, 32'd560, 32'd600, 32'd620, 32'd650,   // double click
        32'd700, 32'd720, 32'd1720, 32'd2720,                   // long press, charging
        32'hFFFF_FFFF, 32'h10, 32'd3010,                        // huge gap, wrap, decay
        32'd4000, 32'd4020, 32'd5100,                           // long seen at release
        32'd6000, 32'd6020, 32'd6050, 32'd6100, 32'd6130,       // second press bounces
        32'd6200, 32'd6220, 32'd6250                            // stale flag: double
    };
    logic [2:0] dir_bits[29] = '{
        3'b101, 3'b010, 3'b000, 3'b100, 3'b100,
        3'b010, 3'b000, 3'b100, 3'b010, 3'b000, 3'b100,
        3'b010, 3'b000, 3'b000, 3'b000,
        3'b000, 3'b100, 3'b100,
        3'b010, 3'b000, 3'b100,
        3'b010, 3'b000, 3'b100, 3'b010, 3'b100,
        3'b011, 3'b000, 3'b100
    };

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial
    begin
        int phase;
        int phase_start;
        rst_n    = 1'b0;
        in_valid = 1'b0;
        in_item  = '0;
        psel     = 1'b0;
        penable  = 1'b0;
        pwrite   = 1'b0;
        paddr    = '0;
        pwdata   = '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < 29; i++)
            send_poll(dir_time[i], dir_bits[i][2], dir_bits[i][1], dir_bits[i][0]);

        now_t = 32'd7000;
        phase = 0;
        while (items_sent < ITEM_TARGET) begin
            // Sender waits for every result before touching the registers.
            drain();
            case (phase)
                0: ;    // stay on reset values
                1: cfg_all(16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 1'b0);    // zero divisors
                2: cfg_all(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1);
                3: cfg_all(16'd1, 16'd1, 16'd1, 16'd1, 16'd1, 1'b0);
                default: cfg_all(16'($urandom_range(0, 60)), 16'($urandom_range(0, 3000)),
                                 16'($urandom_range(0, 800)), 16'($urandom_range(0, 4000)),
                                 16'($urandom_range(0, 5000)), 1'($urandom_range(0, 1)));
            endcase
            if (phase > 0)
                now_t = $urandom;   // fresh time base, wraps land anywhere
            if (phase == 4)
                hold_req = 1;       // receiver backs off for a long stretch now
            phase_start = items_sent;
            while (items_sent - phase_start < PHASE_ITEMS && items_sent < ITEM_TARGET)
                episode();
            phase++;
        end

        in_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
        if (sb.errors == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
